### rtl/rgbd_pkg.sv
// shared constants, types and arithmetic helpers for the rgb error diffusion dither
package rgbd_pkg;

   localparam int MAX_LINE_WIDTH = 1024;
   localparam int LINE_AW        = $clog2(MAX_LINE_WIDTH);
   localparam int CUBE_SIZE      = 216;
   localparam int OUT_DEPTH      = 4;
   localparam int OUT_AW         = $clog2(OUT_DEPTH);

   localparam logic [1:0] OP_DITHER  = 2'd0;
   localparam logic [1:0] OP_PALETTE = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   typedef struct packed {
      logic [7:0] pen_index;
      logic [7:0] cube_index;
   } rsp_beat_type;

   // level 0..5 of one channel sum
   function automatic logic [2:0] quant_level(input logic signed [9:0] sum);
      logic [10:0] prod;
      prod = {1'b0, sum} + {sum, 1'b0};
      if (sum <= 10'sd42) begin
         return 3'd0;
      end else if (sum >= 10'sd213) begin
         return 3'd5;
      end else begin
         return prod[9:7];
      end
   endfunction

   function automatic logic [7:0] cube_of(input logic [2:0] r, input logic [2:0] g,
                                          input logic [2:0] b);
      logic [7:0] c;
      c = {5'b0, r} * 8'd36 + {5'b0, g} * 8'd6 + {5'b0, b};
      return c;
   endfunction

   // clamp far residuals, else halve rounding toward minus infinity
   function automatic logic signed [7:0] next_error(input logic signed [10:0] res);
      logic signed [10:0] half;
      half = res >>> 1;
      if (res <= -11'sd254) begin
         return -8'sd127;
      end else if (res >= 11'sd254) begin
         return 8'sd127;
      end else begin
         return half[7:0];
      end
   endfunction

endpackage

### rtl/rgbd_if.sv
// request and response channel interfaces of the dither block
interface rgbd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic        line_start;
   logic [7:0]  entry_address;
   logic [31:0] entry_word;

   modport source(output valid, opcode, red, green, blue, line_start, entry_address,
                  entry_word, input ready);
   modport sink(input valid, opcode, red, green, blue, line_start, entry_address,
                entry_word, output ready);
endinterface

interface rgbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pen_index;
   logic [7:0] cube_index;

   modport source(output valid, pen_index, cube_index, input ready);
   modport sink(input valid, pen_index, cube_index, output ready);
endinterface

### rtl/rgb_error_diffusion_dither.sv
// rgb error diffusion dither to a 6x6x6 palette cube, top level
//
//   channel  dir  beat contents
//   req_bus  in   opcode, red, green, blue, line_start, entry_address, entry_word
//   rsp_bus  out  pen_index, cube_index (one beat per dither pixel)
//
// one beat a cycle while req_ready is high; a pixel passes the s1 and s2 registers and is
// then written into the result queue, from which its rsp beat is offered
// line store read on accept, palette read in stage 1, errors written back in stage 2
// reset and each clear opcode start a clearing pass over all MAX_LINE_WIDTH (1024) columns,
// which waits for pixels still in flight, with req_ready low
// four-deep result queue: req_ready drops when queued plus in-flight pixels reach four
module rgb_error_diffusion_dither (
   input logic       clock,
   input logic       reset,
   rgbd_req_if.sink  req_bus,
   rgbd_rsp_if.source rsp_bus
);

   localparam logic [rgbd_pkg::LINE_AW-1:0] LAST_COL =
      rgbd_pkg::LINE_AW'(rgbd_pkg::MAX_LINE_WIDTH - 1);

   logic                              req_ok;
   logic [rgbd_pkg::LINE_AW-1:0]      rcol;
   logic [rgbd_pkg::LINE_AW-1:0]      column_ff, column_in;

   // stage 1: line store data arrives, sum and palette lookup
   logic                              s1_valid_ff;
   logic [1:0]                        s1_op_ff;
   logic [7:0]                        s1_pix_ff [3];
   logic                              s1_line_start_ff;
   logic [rgbd_pkg::LINE_AW-1:0]      s1_col_ff;
   logic [7:0]                        s1_addr_ff;
   logic [31:0]                       s1_word_ff;
   logic                              s1_pixel;

   logic                              byp_hit_ff, byp_hit_in;
   logic [23:0]                       byp_data_ff;

   logic [23:0]                       line_mem [rgbd_pkg::MAX_LINE_WIDTH];
   logic [23:0]                       line_rdata_ff;
   logic                              line_we;
   logic [rgbd_pkg::LINE_AW-1:0]      line_waddr;
   logic [23:0]                       line_wdata;

   logic [31:0]                       pal_mem [rgbd_pkg::CUBE_SIZE];
   logic [31:0]                       pal_rdata_ff;
   logic                              pal_we;

   logic signed [7:0]                 run_s1 [3];
   logic signed [7:0]                 line_s1 [3];
   logic signed [9:0]                 sum_s1 [3];
   logic [2:0]                        lvl_s1 [3];
   logic [7:0]                        cube_s1;
   logic                              line_fwd;

   // stage 2: palette data arrives, residual and write back
   logic                              s2_pix_ff;
   logic signed [9:0]                 s2_sum_ff [3];
   logic [rgbd_pkg::LINE_AW-1:0]      s2_col_ff;
   logic [7:0]                        s2_cube_ff;
   logic signed [10:0]                res_s2 [3];
   logic signed [7:0]                 err_s2 [3];

   logic signed [7:0]                 running_error_ff [3];

   logic                              clear_busy_ff, clear_busy_in;
   logic [rgbd_pkg::LINE_AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic                              clear_step;

   logic [rgbd_pkg::OUT_AW:0]         q_fill;
   logic [rgbd_pkg::OUT_AW:0]         pending;
   rgbd_pkg::rsp_beat_type            push_beat;
   rgbd_pkg::rsp_beat_type            out_beat;
   logic                              out_valid;

   assign req_ok   = req_bus.valid && req_bus.ready;
   assign rcol     = req_bus.line_start ? '0 : column_ff;
   assign s1_pixel = s1_valid_ff && (s1_op_ff == rgbd_pkg::OP_DITHER);

   assign pending = q_fill + (rgbd_pkg::OUT_AW + 1)'(s1_pixel)
                  + (rgbd_pkg::OUT_AW + 1)'(s2_pix_ff);
   assign req_bus.ready = !clear_busy_ff
                        && (pending < (rgbd_pkg::OUT_AW + 1)'(rgbd_pkg::OUT_DEPTH));

   // column advances per pixel beat
   always_comb begin
      column_in = column_ff;
      if (req_ok && req_bus.opcode == rgbd_pkg::OP_DITHER) begin
         column_in = (rcol == LAST_COL) ? '0 : rcol + 1'b1;
      end
   end

   // stage 2 residuals
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         res_s2[ch] = {s2_sum_ff[ch][9], s2_sum_ff[ch]}
                    - {3'b000, pal_rdata_ff[23 - 8 * ch -: 8]};
         err_s2[ch] = rgbd_pkg::next_error(res_s2[ch]);
      end
   end

   // stage 1 sums with forwarding from the pixel ahead
   assign line_fwd = s2_pix_ff && (s2_col_ff == s1_col_ff);

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         if (s1_line_start_ff) begin
            run_s1[ch] = '0;
         end else if (s2_pix_ff) begin
            run_s1[ch] = err_s2[ch];
         end else begin
            run_s1[ch] = running_error_ff[ch];
         end
         if (line_fwd) begin
            line_s1[ch] = err_s2[ch];
         end else if (byp_hit_ff) begin
            line_s1[ch] = byp_data_ff[23 - 8 * ch -: 8];
         end else begin
            line_s1[ch] = line_rdata_ff[23 - 8 * ch -: 8];
         end
         sum_s1[ch] = {{2{run_s1[ch][7]}}, run_s1[ch]}
                    + {{2{line_s1[ch][7]}}, line_s1[ch]}
                    + {2'b00, s1_pix_ff[ch]};
         lvl_s1[ch] = rgbd_pkg::quant_level(sum_s1[ch]);
      end
      cube_s1 = rgbd_pkg::cube_of(lvl_s1[0], lvl_s1[1], lvl_s1[2]);
   end

   // line store write port: pixel write back wins, clearing pass waits for it
   assign clear_step = clear_busy_ff && !s1_pixel && !s2_pix_ff;
   assign line_we    = s2_pix_ff || clear_step;
   assign line_waddr = s2_pix_ff ? s2_col_ff : clr_cnt_ff;
   assign line_wdata = s2_pix_ff ? {err_s2[0], err_s2[1], err_s2[2]} : '0;

   // same-edge read and write of one column
   assign byp_hit_in = req_ok && (req_bus.opcode == rgbd_pkg::OP_DITHER)
                     && s2_pix_ff && (s2_col_ff == rcol);

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (req_ok && req_bus.opcode == rgbd_pkg::OP_CLEAR) begin
         clear_busy_in = 1'b1;
         clr_cnt_in    = '0;
      end else if (clear_step) begin
         if (clr_cnt_ff == LAST_COL) begin
            clear_busy_in = 1'b0;
         end
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
   end

   assign pal_we = s1_valid_ff && (s1_op_ff == rgbd_pkg::OP_PALETTE)
                 && (s1_addr_ff < 8'(rgbd_pkg::CUBE_SIZE));

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_waddr] <= line_wdata;
      end
      line_rdata_ff <= line_mem[rcol];
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[s1_addr_ff] <= s1_word_ff;
      end
      pal_rdata_ff <= pal_mem[cube_s1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         s1_valid_ff   <= 1'b0;
         s2_pix_ff     <= 1'b0;
         byp_hit_ff    <= 1'b0;
         clear_busy_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         for (int ch = 0; ch < 3; ch++) begin
            running_error_ff[ch] <= '0;
         end
      end else begin
         column_ff     <= column_in;
         s1_valid_ff   <= req_ok;
         s2_pix_ff     <= s1_pixel;
         byp_hit_ff    <= byp_hit_in;
         clear_busy_ff <= clear_busy_in;
         clr_cnt_ff    <= clr_cnt_in;
         if (s2_pix_ff) begin
            for (int ch = 0; ch < 3; ch++) begin
               running_error_ff[ch] <= err_s2[ch];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_op_ff         <= req_bus.opcode;
      s1_pix_ff[0]     <= req_bus.red;
      s1_pix_ff[1]     <= req_bus.green;
      s1_pix_ff[2]     <= req_bus.blue;
      s1_line_start_ff <= req_bus.line_start;
      s1_col_ff        <= rcol;
      s1_addr_ff       <= req_bus.entry_address;
      s1_word_ff       <= req_bus.entry_word;
      byp_data_ff      <= line_wdata;
      s2_col_ff        <= s1_col_ff;
      s2_cube_ff       <= cube_s1;
      for (int ch = 0; ch < 3; ch++) begin
         s2_sum_ff[ch] <= sum_s1[ch];
      end
   end

   assign push_beat.pen_index  = pal_rdata_ff[31:24];
   assign push_beat.cube_index = s2_cube_ff;

   rgbd_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_pix_ff),
      .push_beat (push_beat),
      .pop       (rsp_bus.ready),
      .out_valid (out_valid),
      .out_beat  (out_beat),
      .fill      (q_fill)
   );

   assign rsp_bus.valid      = out_valid;
   assign rsp_bus.pen_index  = out_beat.pen_index;
   assign rsp_bus.cube_index = out_beat.cube_index;

endmodule

### rtl/rgbd_out_fifo.sv
// small result queue that decouples the dither pipeline from the response channel
module rgbd_out_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rgbd_pkg::rsp_beat_type     push_beat,
   input  logic                       pop,
   output logic                       out_valid,
   output rgbd_pkg::rsp_beat_type     out_beat,
   output logic [rgbd_pkg::OUT_AW:0]  fill
);

   rgbd_pkg::rsp_beat_type            entries_ff [rgbd_pkg::OUT_DEPTH];
   logic [rgbd_pkg::OUT_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rgbd_pkg::OUT_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rgbd_pkg::OUT_AW:0]         count_ff, count_in;
   logic                              do_pop;

   assign out_valid = (count_ff != '0);
   assign out_beat  = entries_ff[rd_ptr_ff];
   assign fill      = count_ff;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

### sim/tb_rgb_error_diffusion_dither.sv
// self-checking testbench for the rgb error diffusion dither top level
`timescale 1ns / 100ps

module tb_rgb_error_diffusion_dither;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         LVL_LOW_MAX  = 42;
   localparam int         LVL_HIGH_MIN = 213;
   localparam int         LVL_TOP      = 5;
   localparam int         ERR_CLAMP_AT = 254;
   localparam int         ERR_CLAMP    = 127;
   localparam int         RANDOM_ITEMS = 1450;
   localparam int         PAUSE_AFTER  = 1380;
   localparam int         LONG_ROW     = 1040;
   localparam int         DRAIN_CYCLES = 16;
   localparam int         CYCLE_LIMIT  = 300000;

   typedef struct {
      logic [1:0]  opcode;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        line_start;
      logic [7:0]  entry_address;
      logic [31:0] entry_word;
      bit          hold;
   } req_job_type;

   logic clock;
   logic reset;

   rgbd_req_if req_bus();
   rgbd_rsp_if rsp_bus();

   rgb_error_diffusion_dither i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   req_job_type            req_pending[$];
   rgbd_pkg::rsp_beat_type pen_expect[$];

   // shadow of the block state
   logic signed [7:0] carry_err [3];
   logic signed [7:0] row_err [rgbd_pkg::MAX_LINE_WIDTH][3];
   logic [31:0]       pal_mem [rgbd_pkg::CUBE_SIZE];
   int unsigned       col_pos;

   int  fail_count;
   int  cycle_count;
   int  req_beat_count;
   int  rsp_beat_count;
   bit  req_taken;
   int  stall_left;
   bit  stall_done;
   wire steady = (req_beat_count >= 1000) && (req_beat_count < 1400);

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [23:0] cube_color(input int addr);
      int r;
      int g;
      int b;
      r = addr / 36;
      g = (addr / 6) % 6;
      b = addr % 6;
      return {8'(r * 51), 8'(g * 51), 8'(b * 51)};
   endfunction

   function automatic int quant_of(input int sum);
      if (sum <= LVL_LOW_MAX) begin
         return 0;
      end else if (sum >= LVL_HIGH_MIN) begin
         return LVL_TOP;
      end else begin
         return (sum * 3) / 128;
      end
   endfunction

   function automatic void predict_dither(input req_job_type it);
      int                     sum [3];
      int                     lvl [3];
      int                     pix;
      int                     cerr;
      int                     rerr;
      int                     res;
      int                     e;
      int                     cube;
      logic [31:0]            w;
      rgbd_pkg::rsp_beat_type beat;
      unique case (it.opcode)
         rgbd_pkg::OP_PALETTE: begin
            if (it.entry_address < rgbd_pkg::CUBE_SIZE) begin
               pal_mem[it.entry_address] = it.entry_word;
            end
         end
         rgbd_pkg::OP_CLEAR: begin
            for (int c = 0; c < rgbd_pkg::MAX_LINE_WIDTH; c++) begin
               for (int ch = 0; ch < 3; ch++) begin
                  row_err[c][ch] = '0;
               end
            end
         end
         rgbd_pkg::OP_DITHER: begin
            if (it.line_start) begin
               col_pos = 0;
               for (int ch = 0; ch < 3; ch++) begin
                  carry_err[ch] = '0;
               end
            end
            for (int ch = 0; ch < 3; ch++) begin
               pix = (ch == 0) ? it.red : (ch == 1) ? it.green : it.blue;
               cerr = carry_err[ch];
               rerr = row_err[col_pos][ch];
               sum[ch] = cerr + rerr + pix;
               lvl[ch] = quant_of(sum[ch]);
            end
            cube = (lvl[0] * 6 + lvl[1]) * 6 + lvl[2];
            w = pal_mem[cube];
            for (int ch = 0; ch < 3; ch++) begin
               res = sum[ch] - int'((w >> (16 - 8 * ch)) & 32'hFF);
               if (res <= -ERR_CLAMP_AT) begin
                  e = -ERR_CLAMP;
               end else if (res >= ERR_CLAMP_AT) begin
                  e = ERR_CLAMP;
               end else begin
                  // floor halving
                  e = res >>> 1;
               end
               carry_err[ch] = 8'(e);
               row_err[col_pos][ch] = 8'(e);
            end
            col_pos = (col_pos + 1) % rgbd_pkg::MAX_LINE_WIDTH;
            beat.pen_index = w[31:24];
            beat.cube_index = 8'(cube);
            pen_expect.push_back(beat);
         end
         default: begin
         end
      endcase
   endfunction

   task automatic push_job(input logic [1:0] opcode, input logic [7:0] red,
                           input logic [7:0] green, input logic [7:0] blue,
                           input logic line_start, input logic [7:0] addr,
                           input logic [31:0] word, input bit hold);
      req_job_type it;
      it.opcode = opcode;
      it.red = red;
      it.green = green;
      it.blue = blue;
      it.line_start = line_start;
      it.entry_address = addr;
      it.entry_word = word;
      it.hold = hold;
      req_pending.push_back(it);
   endtask

   task automatic push_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic line_start, input bit hold);
      push_job(rgbd_pkg::OP_DITHER, red, green, blue, line_start, 8'($urandom()),
               $urandom(), hold);
   endtask

   task automatic push_palette(input logic [7:0] addr, input logic [31:0] word);
      push_job(rgbd_pkg::OP_PALETTE, 8'($urandom()), 8'($urandom()), 8'($urandom()),
               1'($urandom()), addr, word, 1'b0);
   endtask

   task automatic push_clear();
      push_job(rgbd_pkg::OP_CLEAR, 8'($urandom()), 8'($urandom()), 8'($urandom()),
               1'($urandom()), 8'($urandom()), $urandom(), 1'b0);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (req_pending.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (req_pending[0].hold && pen_expect.size() != 0) begin
            req_bus.valid <= 1'b0;
         end else if (!steady && $urandom_range(99) < 30) begin
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.opcode <= req_pending[0].opcode;
            req_bus.red <= req_pending[0].red;
            req_bus.green <= req_pending[0].green;
            req_bus.blue <= req_pending[0].blue;
            req_bus.line_start <= req_pending[0].line_start;
            req_bus.entry_address <= req_pending[0].entry_address;
            req_bus.entry_word <= req_pending[0].entry_word;
            req_bus.valid <= 1'b1;
            void'(req_pending.pop_front());
         end
      end
   end

   // result receiver, with one long hold-off to back up the block
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!stall_done && rsp_beat_count >= 600) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 400;
         stall_done <= 1'b1;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(99) >= 30);
      end
   end

   // monitor: predicts on each req beat, checks each rsp beat
   always @(posedge clock) begin
      req_job_type            seen;
      rgbd_pkg::rsp_beat_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            rsp_beat_count++;
            if (pen_expect.size() == 0) begin
               $error("unexpected rsp beat pen_index %0d cube_index %0d",
                      rsp_bus.pen_index, rsp_bus.cube_index);
               fail_count++;
            end else begin
               want = pen_expect.pop_front();
               if (rsp_bus.pen_index !== want.pen_index) begin
                  $error("pen_index expected %0d actual %0d", want.pen_index,
                         rsp_bus.pen_index);
                  fail_count++;
               end
               if (rsp_bus.cube_index !== want.cube_index) begin
                  $error("cube_index expected %0d actual %0d", want.cube_index,
                         rsp_bus.cube_index);
                  fail_count++;
               end
            end
         end
         if (!reset && req_bus.valid && req_bus.ready) begin
            req_beat_count++;
            seen.opcode = req_bus.opcode;
            seen.red = req_bus.red;
            seen.green = req_bus.green;
            seen.blue = req_bus.blue;
            seen.line_start = req_bus.line_start;
            seen.entry_address = req_bus.entry_address;
            seen.entry_word = req_bus.entry_word;
            seen.hold = 1'b0;
            predict_dither(seen);
         end
         req_taken <= !reset && req_bus.valid && req_bus.ready;
      end
   end

   initial begin
      int  random_items;
      int  pick;
      int  row_len;
      bit  long_row_done;
      bit  pause_done;
      bit  pause_now;
      logic [7:0] addr;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = rgbd_pkg::OP_DITHER;
      req_bus.red = '0;
      req_bus.green = '0;
      req_bus.blue = '0;
      req_bus.line_start = 1'b0;
      req_bus.entry_address = '0;
      req_bus.entry_word = '0;
      rsp_bus.ready = 1'b0;
      fail_count = 0;
      cycle_count = 0;
      req_beat_count = 0;
      rsp_beat_count = 0;
      req_taken = 1'b0;
      stall_left = 0;
      stall_done = 1'b0;
      col_pos = 0;
      for (int ch = 0; ch < 3; ch++) begin
         carry_err[ch] = '0;
      end
      for (int c = 0; c < rgbd_pkg::MAX_LINE_WIDTH; c++) begin
         for (int ch = 0; ch < 3; ch++) begin
            row_err[c][ch] = '0;
         end
      end

      // load the whole palette so that no dither reads an unwritten entry
      for (int a = 0; a < rgbd_pkg::CUBE_SIZE; a++) begin
         push_palette(8'(a), {8'($urandom()), cube_color(a)});
      end

      // directed: level boundaries, clamping both ways, ignored beats, one pause
      push_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
      push_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
      push_pixel(8'd42, 8'd43, 8'd212, 1'b1, 1'b0);
      push_pixel(8'd213, 8'd128, 8'd1, 1'b0, 1'b0);
      push_palette(8'd0, 32'h5AFF_FFFF);
      push_palette(8'(rgbd_pkg::CUBE_SIZE - 1), 32'hC300_0000);
      push_clear();
      push_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
      push_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
      push_clear();
      push_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
      push_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
      push_palette(8'd0, {8'h00, cube_color(0)});
      push_palette(8'(rgbd_pkg::CUBE_SIZE - 1),
                   {8'hFF, cube_color(rgbd_pkg::CUBE_SIZE - 1)});
      push_palette(8'(rgbd_pkg::CUBE_SIZE), $urandom());
      push_palette(8'd255, 32'hFFFF_FFFF);
      push_job(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b0);
      push_pixel(8'd128, 8'd64, 8'd32, 1'b1, 1'b1);
      push_pixel(8'd17, 8'd200, 8'd99, 1'b0, 1'b0);
      push_pixel(8'd170, 8'd85, 8'd0, 1'b0, 1'b0);

      // random rows of pixels, with palette updates, clears and noise between them
      random_items = 0;
      long_row_done = 1'b0;
      pause_done = 1'b0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (!long_row_done && random_items >= 300) begin
            // row that runs past the end of the line store
            long_row_done = 1'b1;
            for (int i = 0; i < LONG_ROW; i++) begin
               push_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()), i == 0, 1'b0);
            end
            random_items += LONG_ROW;
         end else if (pick < 6) begin
            addr = 8'($urandom_range(255));
            if ($urandom_range(1) == 0 && addr < rgbd_pkg::CUBE_SIZE) begin
               push_palette(addr, {8'($urandom()), cube_color(addr)});
            end else begin
               push_palette(addr, $urandom());
            end
            if (addr < rgbd_pkg::CUBE_SIZE) begin
               random_items++;
            end
         end else if (pick < 8) begin
            push_job(OP_UNUSED, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                     1'($urandom()), 8'($urandom()), $urandom(), 1'b0);
         end else if (pick < 12) begin
            push_clear();
            random_items++;
         end else begin
            row_len = $urandom_range(48, 1);
            pause_now = !pause_done && random_items >= PAUSE_AFTER;
            if (pause_now) begin
               pause_done = 1'b1;
            end
            for (int i = 0; i < row_len; i++) begin
               push_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()),
                          i == 0 && $urandom_range(99) < 85, pause_now && i == 0);
            end
            random_items += row_len;
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_pending.size() != 0 || req_bus.valid || pen_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
